// ===== hdl/ndpna_pkg.sv =====
// Shared types and constants for the neighbor advertisement responder.
`timescale 1ns / 1ps
package ndpna_pkg;

  localparam int MAC_W  = 48;
  localparam int ADDR_W = 128;
  localparam int WORD_W = 16;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 6;
  localparam int SUM_W  = 22;

  localparam logic [MAC_W-1:0] LOCAL_MAC_RESET = 48'hFC00_0000_0000;
  localparam logic [7:0]       NS_TYPE         = 8'd135;
  localparam logic [7:0]       NA_TYPE         = 8'd136;

  // Byte positions within the received frame.
  localparam logic [POS_W-1:0] POS_MAX        = 7'd127;
  localparam logic [POS_W-1:0] POS_MAC_FIRST  = 7'd6;
  localparam logic [POS_W-1:0] POS_MAC_LAST   = 7'd11;
  localparam logic [POS_W-1:0] POS_PEER_FIRST = 7'd22;
  localparam logic [POS_W-1:0] POS_PEER_LAST  = 7'd37;
  localparam logic [POS_W-1:0] POS_TYPE       = 7'd54;
  localparam logic [POS_W-1:0] POS_TGT_FIRST  = 7'd62;
  localparam logic [POS_W-1:0] POS_TGT_LAST   = 7'd77;

  // Reply word indexes.
  localparam logic [IDX_W-1:0] LAST_WORD = 6'd46;

  // Fixed checksum terms: length 40, next header 58, type/code 0x8800,
  // flags 0xE000 and the two option headers 0x0201 and 0x0101.
  localparam logic [SUM_W-1:0] CSUM_CONST = SUM_W'(40 + 58 + 'h8800 + 'hE000 + 'h0201 + 'h0101);

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  typedef struct packed {
    logic [MAC_W-1:0]  peer_mac;
    logic [ADDR_W-1:0] peer_ip;
    logic [ADDR_W-1:0] target_ip;
    logic [MAC_W-1:0]  local_mac;
    logic [SUM_W-1:0]  part_sum;
  } job_t;

endpackage

// ===== hdl/ndpna_in_if.sv =====
// Frame byte channel.
`timescale 1ns / 1ps
interface ndpna_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/ndpna_out_if.sv =====
// Reply word channel.
`timescale 1ns / 1ps
interface ndpna_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reply_word;
  logic        reply_last;

  modport source(output valid, output reply_word, output reply_last, input ready);
  modport sink(input valid, input reply_word, input reply_last, output ready);
endinterface

// ===== hdl/ndpna_cfg_if.sv =====
// Configuration write channel for the local MAC address.
`timescale 1ns / 1ps
interface ndpna_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] local_mac;

  modport source(output valid, output local_mac, input ready);
  modport sink(input valid, input local_mac, output ready);
endinterface

// ===== hdl/ndpna_front.sv =====
// Frame capture: tracks byte position, captures addresses and builds reply jobs.
`timescale 1ns / 1ps
module ndpna_front import ndpna_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             cfg_we,
  input  logic [MAC_W-1:0] cfg_data,
  output logic             push,
  output job_t             job
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [MAC_W-1:0]  peer_mac_r, peer_mac_nxt;
  logic [ADDR_W-1:0] peer_ip_r, peer_ip_nxt;
  logic [ADDR_W-1:0] target_ip_r, target_ip_nxt;
  logic [7:0]        msg_type_r, msg_type_nxt;
  logic [SUM_W-1:0]  part_sum_r, part_sum_nxt;
  logic [MAC_W-1:0]  local_mac_r;

  logic              in_mac, in_peer, in_tgt;
  logic [WORD_W-1:0] byte_word;
  logic [SUM_W-1:0]  contrib, base;

  always_comb begin
    in_mac  = (pos_r >= POS_MAC_FIRST) && (pos_r <= POS_MAC_LAST);
    in_peer = (pos_r >= POS_PEER_FIRST) && (pos_r <= POS_PEER_LAST);
    in_tgt  = (pos_r >= POS_TGT_FIRST) && (pos_r <= POS_TGT_LAST);

    peer_mac_nxt  = in_mac  ? {peer_mac_r[MAC_W-9:0], data_byte} : peer_mac_r;
    peer_ip_nxt   = in_peer ? {peer_ip_r[ADDR_W-9:0], data_byte} : peer_ip_r;
    target_ip_nxt = in_tgt  ? {target_ip_r[ADDR_W-9:0], data_byte} : target_ip_r;
    msg_type_nxt  = (pos_r == POS_TYPE) ? data_byte : msg_type_r;

    // Even positions are the upper byte of a checksum word. The target address
    // appears twice in the reply, so its bytes count double.
    byte_word = pos_r[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
    if (in_tgt) begin
      contrib = SUM_W'({byte_word, 1'b0});
    end else if (in_mac || in_peer) begin
      contrib = SUM_W'(byte_word);
    end else begin
      contrib = '0;
    end
    base         = (pos_r == '0) ? '0 : part_sum_r;
    part_sum_nxt = base + contrib;

    if (last_byte) begin
      pos_nxt = '0;
    end else if (pos_r == POS_MAX) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end

    push = accept && last_byte && (pos_r >= POS_TGT_LAST) && (msg_type_r == NS_TYPE);

    job.peer_mac  = peer_mac_nxt;
    job.peer_ip   = peer_ip_nxt;
    job.target_ip = target_ip_nxt;
    job.local_mac = local_mac_r;
    job.part_sum  = part_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      peer_mac_r  <= '0;
      peer_ip_r   <= '0;
      target_ip_r <= '0;
      msg_type_r  <= '0;
      part_sum_r  <= '0;
      local_mac_r <= LOCAL_MAC_RESET;
    end else begin
      if (cfg_we) begin
        local_mac_r <= cfg_data;
      end
      if (accept) begin
        pos_r       <= pos_nxt;
        peer_mac_r  <= peer_mac_nxt;
        peer_ip_r   <= peer_ip_nxt;
        target_ip_r <= target_ip_nxt;
        msg_type_r  <= msg_type_nxt;
        part_sum_r  <= part_sum_nxt;
      end
    end
  end

endmodule

// ===== hdl/ndpna_job_queue.sv =====
// Short queue of pending reply jobs between capture and reply generation.
`timescale 1ns / 1ps
module ndpna_job_queue import ndpna_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t                 entry_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_CNT_W-1:0] count_r;

  function automatic logic [JOB_PTR_W-1:0] ptr_inc(input logic [JOB_PTR_W-1:0] p);
    logic [JOB_PTR_W-1:0] q;
    if (p == JOB_PTR_W'(JOB_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  assign full       = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ndpna_back.sv =====
// Reply generation: emits the 47 advertisement words of the head job.
`timescale 1ns / 1ps
module ndpna_back import ndpna_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  job_t              head_job,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_word,
  output logic              out_last
);

  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [WORD_W-1:0] csum_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;

  logic              advance;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  tgt_a, peer_i, tgt_b;
  logic [16:0]       fold1;
  logic [WORD_W-1:0] fold2;

  function automatic logic [WORD_W-1:0] addr_word(input logic [ADDR_W-1:0] a,
                                                  input logic [2:0] k);
    return a[{~k, 4'b0000} +: WORD_W];
  endfunction

  always_comb begin
    advance = head_valid && (!out_valid_r || out_ready);
    pop     = advance && (idx_r == LAST_WORD);

    tgt_a  = idx_r - 6'd11;
    peer_i = idx_r - 6'd19;
    tgt_b  = idx_r - 6'd31;

    fold1 = 17'(sum_r[SUM_W-1:WORD_W]) + 17'(sum_r[WORD_W-1:0]);
    fold2 = fold1[WORD_W-1:0] + WORD_W'(fold1[16]);

    unique case (idx_r) inside
      6'd0:           word = head_job.peer_mac[47:32];
      6'd1:           word = head_job.peer_mac[31:16];
      6'd2:           word = head_job.peer_mac[15:0];
      6'd3:           word = head_job.local_mac[47:32];
      6'd4:           word = head_job.local_mac[31:16];
      6'd5:           word = head_job.local_mac[15:0];
      6'd6:           word = 16'h86DD;
      6'd7:           word = 16'h6000;
      6'd8:           word = 16'h0000;
      6'd9:           word = 16'h0028;
      6'd10:          word = 16'h3AFF;
      [6'd11:6'd18]:  word = addr_word(head_job.target_ip, tgt_a[2:0]);
      [6'd19:6'd26]:  word = addr_word(head_job.peer_ip, peer_i[2:0]);
      6'd27:          word = {NA_TYPE, 8'h00};
      6'd28:          word = csum_r;
      6'd29:          word = 16'hE000;
      6'd30:          word = 16'h0000;
      [6'd31:6'd38]:  word = addr_word(head_job.target_ip, tgt_b[2:0]);
      6'd39:          word = 16'h0201;
      6'd40:          word = head_job.local_mac[47:32];
      6'd41:          word = head_job.local_mac[31:16];
      6'd42:          word = head_job.local_mac[15:0];
      6'd43:          word = 16'h0101;
      6'd44:          word = head_job.peer_mac[47:32];
      6'd45:          word = head_job.peer_mac[31:16];
      6'd46:          word = head_job.peer_mac[15:0];
      default:        word = 16'h0000;
    endcase
  end

  // The checksum sum is completed while word 0 goes out and folded on word 1,
  // well before word 28 needs it.
  always_ff @(posedge clk) begin
    if (advance && (idx_r == 6'd0)) begin
      sum_r <= head_job.part_sum + CSUM_CONST
             + SUM_W'(head_job.local_mac[47:32])
             + SUM_W'(head_job.local_mac[31:16])
             + SUM_W'(head_job.local_mac[15:0]);
    end
    if (advance && (idx_r == 6'd1)) begin
      csum_r <= ~fold2;
    end
    if (advance) begin
      out_word_r <= word;
      out_last_r <= (idx_r == LAST_WORD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= (idx_r == LAST_WORD) ? '0 : idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/ndp_neighbor_advert_responder_unit.sv =====
// IPv6 neighbor advertisement responder, top level.
// Channels: in_if carries one received Ethernet frame byte per transfer, with
// last_byte set on the final byte; out_if carries the reply as 16-bit words,
// earlier byte in the upper half, reply_last set on the 47th word; cfg_if
// writes the local MAC address and is always ready.
// A frame of at least 78 bytes whose ICMPv6 type byte is 135 produces one
// 94-byte neighbor advertisement. Other frames produce nothing.
// Throughput: one frame byte per cycle while the queue is not full, one reply
// word per cycle while out_if is ready. After the last frame byte, the job is
// registered in the job queue and each reply word in the output register.
// Replies wait in a two-entry job queue; in_if.ready drops only while that
// queue is full, so a stalled receiver holds back input once two replies
// are pending. Output words are held in a register and stay stable while
// out_if.ready is low.
// Reset (rst_n low at a clock edge) empties the queue and the output
// register, restarts the frame position and sets the local MAC to
// FC:00:00:00:00:00.
`timescale 1ns / 1ps
module ndp_neighbor_advert_responder_unit import ndpna_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  ndpna_in_if.sink    in_if,
  ndpna_out_if.source out_if,
  ndpna_cfg_if.sink   cfg_if
);

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic head_valid;
  job_t head_job;

  assign in_if.ready  = !full;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && !full;

  ndpna_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_if.data_byte),
    .last_byte (in_if.last_byte),
    .cfg_we    (cfg_if.valid),
    .cfg_data  (cfg_if.local_mac),
    .push      (push),
    .job       (push_job)
  );

  ndpna_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ndpna_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_word   (out_if.reply_word),
    .out_last   (out_if.reply_last)
  );

endmodule

// ===== hdl/ndpna_checker.sv =====
// Port-level checks for the responder and their binding to the top level.
`timescale 1ns / 1ps
module ndpna_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_word,
  input logic        out_last
);

  // Coming out of reset the queue is empty and nothing is on the output.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("output not idle or input not ready after reset");

  // A reply's final word is never directly followed by another final word.
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !(out_valid && out_last))
    else $error("two final reply words in a row");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("reply word withdrawn while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
    else $error("reply word changed while stalled");

endmodule

bind ndp_neighbor_advert_responder_unit ndpna_checker u_ndpna_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_word  (out_if.reply_word),
  .out_last  (out_if.reply_last)
);
